FILE: rtl/tfcs_pkg.sv
`timescale 1ns / 1ps
package tfcs_pkg;

    localparam int FRAME_W   = 16;
    localparam int STAMP_W   = 32;
    localparam int SEQ_W     = 32;
    localparam int VOLT_W    = 17;
    localparam int TEMP_W    = 16;
    localparam int CFG_W     = 16;
    localparam int SUM_W     = 33;
    localparam int RATE_W    = 26;
    localparam int STATUS_W  = 3;
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [FRAME_W-1:0] FRAME_LIMIT    = 16'hFFFF;
    localparam logic [9:0]         RATE_SCALE     = 10'd1000;
    localparam logic [CFG_W-1:0]   LOW_VOLT_RST   = 16'd22000;
    localparam logic [CFG_W-1:0]   TEMP_FLOOR_RST = 16'hFE70;
    localparam logic [CFG_W-1:0]   TEMP_CEIL_RST  = 16'd1200;

    typedef enum logic [STATUS_W-1:0] {
        STS_SUMMARY = 3'd0,
        STS_TIME    = 3'd1,
        STS_SEQ     = 3'd2,
        STS_VOLT    = 3'd3,
        STS_CURR    = 3'd4,
        STS_TEMP    = 3'd5,
        STS_GPS     = 3'd6,
        STS_SATS    = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        CFG_LOW_VOLT   = 2'd0,
        CFG_TEMP_FLOOR = 2'd1,
        CFG_TEMP_CEIL  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_AVG_WAIT,
        ST_RATE,
        ST_RATE_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0]        low_voltage_mv;
        logic signed [CFG_W-1:0] temp_floor_dc;
        logic signed [CFG_W-1:0] temp_ceiling_dc;
    } t_cfg;

    typedef struct packed {
        logic               have_previous;
        logic [STAMP_W-1:0] previous_stamp;
        logic [SEQ_W-1:0]   previous_seq;
    } t_hist;

endpackage

FILE: rtl/telemetry_frame_checker_stats.sv
`timescale 1ns / 1ps
// A frame that is not the last of its log is checked and accumulated in the cycle it is
// accepted, so such frames can be taken back to back; the first failing frame of a log
// loads its error beat into the output register at the edge that accepts it. The last
// frame of a log that passed every check starts the end-of-log statistics: the
// temperature average and the rate are both worked out by one shared 32-step restoring
// divider, used twice in turn unless the rate is zero without a division (a single counted
// frame or no elapsed time); input is held off until the summary beat is loaded, and also
// while a finished result beat waits in the output register and is not being taken.
module telemetry_frame_checker_stats import tfcs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [STAMP_W-1:0]       i_stamp_ms,
    input  logic [SEQ_W-1:0]         i_frame_seq,
    input  logic signed [VOLT_W-1:0] i_voltage_mv,
    input  logic signed [VOLT_W-1:0] i_current_ma,
    input  logic signed [TEMP_W-1:0] i_temperature_dc,
    input  logic [7:0]               i_gps_fix,
    input  logic signed [7:0]        i_satellites,
    input  logic                     i_last,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [FRAME_W-1:0]       o_frame_index,
    output logic [FRAME_W-1:0]       o_total_frames,
    output logic signed [VOLT_W-1:0] o_voltage_min_mv,
    output logic signed [VOLT_W-1:0] o_voltage_max_mv,
    output logic signed [TEMP_W-1:0] o_temperature_avg_dc,
    output logic [FRAME_W-1:0]       o_low_volt_frames,
    output logic [RATE_W-1:0]        o_rate_hz
);

    t_state                   r_state;
    t_state                   n_state;
    t_cfg                     r_cfg;
    t_cfg                     n_cfg;
    logic                     r_have_prev;
    logic                     n_have_prev;
    logic                     r_aborted;
    logic                     n_aborted;
    logic [FRAME_W-1:0]       r_frm_cnt;
    logic [FRAME_W-1:0]       n_frm_cnt;
    logic [STAMP_W-1:0]       r_prev_stamp;
    logic [STAMP_W-1:0]       n_prev_stamp;
    logic [STAMP_W-1:0]       r_first_stamp;
    logic [STAMP_W-1:0]       n_first_stamp;
    logic [SEQ_W-1:0]         r_last_seq;
    logic [SEQ_W-1:0]         n_last_seq;
    logic signed [VOLT_W-1:0] r_volt_min;
    logic signed [VOLT_W-1:0] n_volt_min;
    logic signed [VOLT_W-1:0] r_volt_max;
    logic signed [VOLT_W-1:0] n_volt_max;
    logic signed [SUM_W-1:0]  r_temp_sum;
    logic signed [SUM_W-1:0]  n_temp_sum;
    logic [FRAME_W-1:0]       r_low_count;
    logic [FRAME_W-1:0]       n_low_count;
    logic [RATE_W-1:0]        r_num;
    logic [RATE_W-1:0]        n_num;
    logic [TEMP_W-1:0]        r_avg;
    logic [TEMP_W-1:0]        n_avg;
    logic [RATE_W-1:0]        r_rate;
    logic [RATE_W-1:0]        n_rate;

    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [STATUS_W-1:0]      r_out_status;
    logic [STATUS_W-1:0]      n_out_status;
    logic [FRAME_W-1:0]       r_out_index;
    logic [FRAME_W-1:0]       n_out_index;
    logic [FRAME_W-1:0]       r_out_total;
    logic [FRAME_W-1:0]       n_out_total;
    logic signed [VOLT_W-1:0] r_out_vmin;
    logic signed [VOLT_W-1:0] n_out_vmin;
    logic signed [VOLT_W-1:0] r_out_vmax;
    logic signed [VOLT_W-1:0] n_out_vmax;
    logic [TEMP_W-1:0]        r_out_avg;
    logic [TEMP_W-1:0]        n_out_avg;
    logic [FRAME_W-1:0]       r_out_low;
    logic [FRAME_W-1:0]       n_out_low;
    logic [RATE_W-1:0]        r_out_rate;
    logic [RATE_W-1:0]        n_out_rate;

    t_hist                    w_hist;
    t_status                  w_status;
    logic                     w_low_volt;
    logic                     w_accept;
    logic                     w_active;
    logic                     w_out_free;
    logic [STAMP_W-1:0]       w_elapsed;
    logic [SUM_W-1:0]         w_sum_neg;
    logic [DIV_W-1:0]         w_sum_abs;
    logic                     w_rate_ok;
    logic                     w_div_start;
    logic [DIV_W-1:0]         w_div_dividend;
    logic [DIV_W-1:0]         w_div_divisor;
    logic                     w_div_done;
    logic [DIV_W-1:0]         w_div_quo;
    logic [FRAME_W-1:0]       w_count_m1;

    assign w_hist.have_previous  = r_have_prev;
    assign w_hist.previous_stamp = r_prev_stamp;
    assign w_hist.previous_seq   = r_last_seq;

    tfcs_frame_check u_check (
        .i_stamp_ms       (i_stamp_ms),
        .i_frame_seq      (i_frame_seq),
        .i_voltage_mv     (i_voltage_mv),
        .i_current_ma     (i_current_ma),
        .i_temperature_dc (i_temperature_dc),
        .i_gps_fix        (i_gps_fix),
        .i_satellites     (i_satellites),
        .i_hist           (w_hist),
        .i_cfg            (r_cfg),
        .o_status         (w_status),
        .o_low_volt       (w_low_volt)
    );

    assign w_elapsed  = r_prev_stamp - r_first_stamp;
    assign w_sum_neg  = -r_temp_sum;
    assign w_sum_abs  = r_temp_sum[SUM_W-1] ? w_sum_neg[DIV_W-1:0] : r_temp_sum[DIV_W-1:0];
    assign w_rate_ok  = (r_frm_cnt > 16'd1) && (w_elapsed != '0);
    assign w_count_m1 = r_frm_cnt - 16'd1;

    assign w_div_start    = (r_state == ST_AVG) || ((r_state == ST_RATE) && w_rate_ok);
    assign w_div_dividend = (r_state == ST_RATE) ? {{(DIV_W - RATE_W){1'b0}}, r_num} : w_sum_abs;
    assign w_div_divisor  = (r_state == ST_RATE) ? w_elapsed
                          : {{(DIV_W - FRAME_W){1'b0}}, r_frm_cnt};

    tfcs_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_valid && o_ready;
    assign w_active   = !r_aborted && (r_frm_cnt < FRAME_LIMIT);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_LOW_VOLT) begin
                n_cfg.low_voltage_mv = i_cfg_data;
            end else if (i_cfg_index == CFG_TEMP_FLOOR) begin
                n_cfg.temp_floor_dc = i_cfg_data;
            end else if (i_cfg_index == CFG_TEMP_CEIL) begin
                n_cfg.temp_ceiling_dc = i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state       = r_state;
        n_have_prev   = r_have_prev;
        n_aborted     = r_aborted;
        n_frm_cnt     = r_frm_cnt;
        n_prev_stamp  = r_prev_stamp;
        n_first_stamp = r_first_stamp;
        n_last_seq    = r_last_seq;
        n_volt_min    = r_volt_min;
        n_volt_max    = r_volt_max;
        n_temp_sum    = r_temp_sum;
        n_low_count   = r_low_count;
        n_num         = r_num;
        n_avg         = r_avg;
        n_rate        = r_rate;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_status  = r_out_status;
        n_out_index   = r_out_index;
        n_out_total   = r_out_total;
        n_out_vmin    = r_out_vmin;
        n_out_vmax    = r_out_vmax;
        n_out_avg     = r_out_avg;
        n_out_low     = r_out_low;
        n_out_rate    = r_out_rate;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_active && (w_status != STS_SUMMARY)) begin
                        n_out_valid  = 1'b1;
                        n_out_status = w_status;
                        n_out_index  = r_frm_cnt + 16'd1;
                        n_out_total  = '0;
                        n_out_vmin   = '0;
                        n_out_vmax   = '0;
                        n_out_avg    = '0;
                        n_out_low    = '0;
                        n_out_rate   = '0;
                        n_aborted    = 1'b1;
                    end else begin
                        if (w_active) begin
                            if (!r_have_prev) begin
                                n_first_stamp = i_stamp_ms;
                                n_volt_min    = i_voltage_mv;
                                n_volt_max    = i_voltage_mv;
                            end else begin
                                if (i_voltage_mv < r_volt_min) begin
                                    n_volt_min = i_voltage_mv;
                                end
                                if (i_voltage_mv > r_volt_max) begin
                                    n_volt_max = i_voltage_mv;
                                end
                            end
                            n_have_prev   = 1'b1;
                            n_prev_stamp  = i_stamp_ms;
                            n_last_seq    = i_frame_seq;
                            n_frm_cnt     = r_frm_cnt + 16'd1;
                            n_temp_sum    = r_temp_sum
                                          + {{(SUM_W - TEMP_W){i_temperature_dc[TEMP_W-1]}},
                                             i_temperature_dc};
                            if (w_low_volt) begin
                                n_low_count = r_low_count + 16'd1;
                            end
                        end
                        if (i_last && !r_aborted && (n_frm_cnt != '0)) begin
                            n_state = ST_AVG;
                        end
                    end
                    if (i_last && (n_state == ST_IDLE)) begin
                        n_have_prev   = 1'b0;
                        n_aborted     = 1'b0;
                        n_frm_cnt     = '0;
                        n_prev_stamp  = '0;
                        n_first_stamp = '0;
                        n_last_seq    = '0;
                        n_volt_min    = '0;
                        n_volt_max    = '0;
                        n_temp_sum    = '0;
                        n_low_count   = '0;
                    end
                end
            end
            ST_AVG: begin
                n_num   = RATE_W'({{(RATE_W - FRAME_W){1'b0}}, w_count_m1}
                                  * {{(RATE_W - 10){1'b0}}, RATE_SCALE});
                n_state = ST_AVG_WAIT;
            end
            ST_AVG_WAIT: begin
                if (w_div_done) begin
                    n_avg   = r_temp_sum[SUM_W-1] ? (~w_div_quo[TEMP_W-1:0] + 16'd1)
                                                  : w_div_quo[TEMP_W-1:0];
                    n_state = ST_RATE;
                end
            end
            ST_RATE: begin
                if (w_rate_ok) begin
                    n_state = ST_RATE_WAIT;
                end else begin
                    n_rate  = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_RATE_WAIT: begin
                if (w_div_done) begin
                    n_rate  = w_div_quo[RATE_W-1:0];
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = STS_SUMMARY;
                    n_out_index   = '0;
                    n_out_total   = r_frm_cnt;
                    n_out_vmin    = r_volt_min;
                    n_out_vmax    = r_volt_max;
                    n_out_avg     = r_avg;
                    n_out_low     = r_low_count;
                    n_out_rate    = r_rate;
                    n_have_prev   = 1'b0;
                    n_aborted     = 1'b0;
                    n_frm_cnt     = '0;
                    n_prev_stamp  = '0;
                    n_first_stamp = '0;
                    n_last_seq    = '0;
                    n_volt_min    = '0;
                    n_volt_max    = '0;
                    n_temp_sum    = '0;
                    n_low_count   = '0;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state                 <= ST_IDLE;
            r_cfg.low_voltage_mv    <= LOW_VOLT_RST;
            r_cfg.temp_floor_dc     <= TEMP_FLOOR_RST;
            r_cfg.temp_ceiling_dc   <= TEMP_CEIL_RST;
            r_have_prev             <= 1'b0;
            r_aborted               <= 1'b0;
            r_frm_cnt               <= '0;
            r_prev_stamp            <= '0;
            r_first_stamp           <= '0;
            r_last_seq              <= '0;
            r_volt_min              <= '0;
            r_volt_max              <= '0;
            r_temp_sum              <= '0;
            r_low_count             <= '0;
            r_out_valid             <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cfg         <= n_cfg;
            r_have_prev   <= n_have_prev;
            r_aborted     <= n_aborted;
            r_frm_cnt     <= n_frm_cnt;
            r_prev_stamp  <= n_prev_stamp;
            r_first_stamp <= n_first_stamp;
            r_last_seq    <= n_last_seq;
            r_volt_min    <= n_volt_min;
            r_volt_max    <= n_volt_max;
            r_temp_sum    <= n_temp_sum;
            r_low_count   <= n_low_count;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num        <= n_num;
        r_avg        <= n_avg;
        r_rate       <= n_rate;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        r_out_total  <= n_out_total;
        r_out_vmin   <= n_out_vmin;
        r_out_vmax   <= n_out_vmax;
        r_out_avg    <= n_out_avg;
        r_out_low    <= n_out_low;
        r_out_rate   <= n_out_rate;
    end

    assign o_cfg_ready          = 1'b1;
    assign o_valid              = r_out_valid;
    assign o_status             = r_out_status;
    assign o_frame_index        = r_out_index;
    assign o_total_frames       = r_out_total;
    assign o_voltage_min_mv     = r_out_vmin;
    assign o_voltage_max_mv     = r_out_vmax;
    assign o_temperature_avg_dc = r_out_avg;
    assign o_low_volt_frames    = r_out_low;
    assign o_rate_hz            = r_out_rate;

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> ((r_state == ST_AVG_WAIT) || (r_state == ST_RATE_WAIT)))
        else $error("divider finished outside a wait state");

    a_error_beat_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STS_SUMMARY)) |->
        ((o_total_frames == '0) && (o_rate_hz == '0) && (o_frame_index != '0)))
        else $error("error beat carries statistics or a zero frame index");

    a_summary_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STS_SUMMARY)) |->
        ((o_total_frames != '0) && (o_frame_index == '0)))
        else $error("summary beat without counted frames");

    a_last_ends_log: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last) |=>
        ((r_state == ST_AVG) || ((r_frm_cnt == '0) && !r_aborted && !r_have_prev)))
        else $error("last frame did not end the log");

endmodule

FILE: rtl/tfcs_divider.sv
`timescale 1ns / 1ps
module tfcs_divider import tfcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 n_busy;
    logic                 r_done;
    logic                 n_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_CNT_W-1:0] n_cnt;
    logic [DIV_W:0]       r_rem;
    logic [DIV_W:0]       n_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     n_quo;
    logic [DIV_W-1:0]     r_dsr;
    logic [DIV_W-1:0]     n_dsr;
    logic [DIV_W:0]       w_shift;
    logic [DIV_W:0]       w_diff;

    // One quotient bit per cycle, restoring form.
    assign w_shift = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            if (!w_diff[DIV_W]) begin
                n_rem = w_diff;
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/tfcs_frame_check.sv
`timescale 1ns / 1ps
module tfcs_frame_check import tfcs_pkg::*; (
    input  logic [STAMP_W-1:0]       i_stamp_ms,
    input  logic [SEQ_W-1:0]         i_frame_seq,
    input  logic signed [VOLT_W-1:0] i_voltage_mv,
    input  logic signed [VOLT_W-1:0] i_current_ma,
    input  logic signed [TEMP_W-1:0] i_temperature_dc,
    input  logic [7:0]               i_gps_fix,
    input  logic signed [7:0]        i_satellites,
    input  t_hist                    i_hist,
    input  t_cfg                     i_cfg,
    output t_status                  o_status,
    output logic                     o_low_volt
);

    logic [SEQ_W-1:0] w_seq_exp;

    assign w_seq_exp  = i_hist.previous_seq + 32'd1;
    assign o_low_volt = $signed({i_voltage_mv[VOLT_W-1], i_voltage_mv})
                      < $signed({2'b00, i_cfg.low_voltage_mv});

    always_comb begin
        priority if (i_hist.have_previous && (i_stamp_ms <= i_hist.previous_stamp)) begin
            o_status = STS_TIME;
        end else if (i_frame_seq != w_seq_exp) begin
            o_status = STS_SEQ;
        end else if (i_voltage_mv[VOLT_W-1] || (i_voltage_mv == '0)) begin
            o_status = STS_VOLT;
        end else if (i_current_ma[VOLT_W-1]) begin
            o_status = STS_CURR;
        end else if ((i_temperature_dc < i_cfg.temp_floor_dc)
                  || (i_temperature_dc > i_cfg.temp_ceiling_dc)) begin
            o_status = STS_TEMP;
        end else if (i_gps_fix > 8'd1) begin
            o_status = STS_GPS;
        end else if (i_satellites[7]) begin
            o_status = STS_SATS;
        end else begin
            o_status = STS_SUMMARY;
        end
    end

endmodule
